// ===== design/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

   // field widths
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;

   // defaults
   localparam int              ENTRIES_DEFAULT = 16;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(16);

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                         operation;
      logic        [KEY_BITS-1:0]   key;
      logic signed [VALUE_BITS-1:0] write_value;
   } lkv_req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [VALUE_BITS-1:0] read_value;
      logic                         evicted;
      logic        [KEY_BITS-1:0]   evicted_key;
   } lkv_rsp_type;

   // what the lookup decided for the current transaction
   typedef struct packed {
      logic hit;      // key present before this transaction
      logic write;    // slot gets key and value
      logic evict;    // least recent entry replaced in place
      logic insert;   // free slot taken, every other valid entry ages
   } lkv_decision_type;

endpackage

`default_nettype wire

// ===== design/lkv_lookup.sv =====
`default_nettype none

module lkv_lookup #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
   parameter int IDX_W   = 1,
   parameter int RANK_W  = 1
) (
   input  wire logic                         op_put,
   input  wire logic [lkv_pkg::KEY_BITS-1:0] key,
   input  wire logic                         full,
   input  wire logic [RANK_W-1:0]            lru_rank,
   input  wire logic [ENTRIES-1:0]           entry_valid,
   input  wire logic [lkv_pkg::KEY_BITS-1:0] entry_key [ENTRIES],
   input  wire logic [RANK_W-1:0]            entry_rank [ENTRIES],
   output      logic [IDX_W-1:0]             slot,
   output      logic [RANK_W-1:0]            old_rank,
   output      lkv_pkg::lkv_decision_type    decision
);
   import lkv_pkg::*;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [IDX_W-1:0]   found_idx;
   logic [IDX_W-1:0]   victim_idx;
   logic [IDX_W-1:0]   free_idx;
   logic               any_hit;

   // parallel key compare, the victim holds the oldest rank
   always_comb begin
      found_idx  = '0;
      victim_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = entry_valid[i] && (entry_key[i] == key);
         victim[i] = entry_valid[i] && (entry_rank[i] == lru_rank);
         if (match[i]) begin
            found_idx = found_idx | IDX_W'(i);
         end
         if (victim[i]) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
   end

   // lowest free entry
   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!entry_valid[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign any_hit = |match;

   always_comb begin
      decision.hit    = any_hit;
      decision.write  = op_put;
      decision.evict  = !any_hit && op_put && full;
      decision.insert = !any_hit && op_put && !full;
      if (any_hit) begin
         slot = found_idx;
      end else if (full) begin
         slot = victim_idx;
      end else begin
         slot = free_idx;
      end
      old_rank = entry_rank[slot];
   end

endmodule

`default_nettype wire

// ===== design/lru_key_value_cache_core.sv =====
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// A transaction is accepted on a clock edge with start high and busy low;
// busy never rises, so one transaction is taken every cycle. Each transaction
// gives exactly one result, shown on rsp_data with rsp_valid high for one
// cycle, after the transaction has passed the input register and then
// the parallel key compare and the update into the result
// register. Results come out in order and the receiver cannot stall them,
// so it must take every strobe. A get returns hit and the stored value; a
// put overwrites a present key or inserts a new one, and when occupancy has
// reached the capacity register it evicts the least recent entry and reports
// its key. Capacity (clamped to 1..ENTRIES) is written on the csr channel,
// which is always ready; write it only while no transaction is in flight and
// preferably while the store is empty, since entries are never flushed. Reset
// clears all valid marks at once, with no clearing pass.
module lru_key_value_cache_core #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request transactions
   input  wire logic                         start,
   output      logic                         busy,
   input  wire lkv_pkg::lkv_req_type         req_data,
   // result transactions
   output      logic                         rsp_valid,
   output      lkv_pkg::lkv_rsp_type         rsp_data,
   // capacity register
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [lkv_pkg::CAP_BITS-1:0] csr_data
);
   import lkv_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

   // capacity register
   logic [CAP_BITS-1:0] cap_ff;
   logic [CMP_W-1:0]    eff_cap;
   logic                full;

   // input stage
   logic        req_vld_ff;
   lkv_req_type req_ff;

   // cache state
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_ff  [ENTRIES];
   logic [RANK_W-1:0]     rank_in  [ENTRIES];
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [OCC_W-1:0]      occ_m1;

   // result stage
   logic        rsp_vld_ff;
   lkv_rsp_type rsp_ff, rsp_in;

   // lookup outcome
   logic [IDX_W-1:0]  slot;
   logic [RANK_W-1:0] old_rank;
   lkv_decision_type  decision;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // clamp capacity to 1..ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
      full = CMP_W'(occ_ff) >= eff_cap;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // ranks among valid entries run 0..occupancy-1, so the oldest is occupancy-1
   assign occ_m1 = occ_ff - OCC_W'(1);

   lkv_lookup #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .RANK_W  (RANK_W)
   ) u_lookup (
      .op_put      (req_ff.operation == OP_PUT),
      .key         (req_ff.key),
      .full        (full),
      .lru_rank    (occ_m1[RANK_W-1:0]),
      .entry_valid (valid_ff),
      .entry_key   (key_ff),
      .entry_rank  (rank_ff),
      .slot        (slot),
      .old_rank    (old_rank),
      .decision    (decision)
   );

   // recency update: touched slot becomes rank 0, younger entries (all others on an insert) age by one
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (req_vld_ff && (decision.hit || decision.write)) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if ((IDX_W'(i) != slot) && valid_ff[i] &&
                (decision.insert || (rank_ff[i] < old_rank))) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         rank_in[slot] = '0;
         if (decision.insert) begin
            valid_in[slot] = 1'b1;
            occ_in         = occ_ff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key and value storage, no reset
   always_ff @(posedge clock) begin
      if (req_vld_ff && decision.write) begin
         value_ff[slot] <= req_ff.write_value;
         if (!decision.hit) begin
            key_ff[slot] <= req_ff.key;
         end
      end
   end

   // result formation
   always_comb begin
      rsp_in.hit         = decision.hit;
      rsp_in.read_value  = '0;
      rsp_in.evicted     = decision.evict;
      rsp_in.evicted_key = '0;
      if (decision.hit && (req_ff.operation == OP_GET)) begin
         rsp_in.read_value = value_ff[slot];
      end
      if (decision.evict) begin
         rsp_in.evicted_key = key_ff[slot];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // occupancy tracks the valid marks
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'($countones(valid_ff)))
      else $error("occupancy does not match valid entries");

   // every accepted transaction gives a result after the input and result registers
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing after accepted transaction");

   // an eviction only happens on a put that missed
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && decision.evict) |=> (rsp_valid && !rsp_data.hit))
      else $error("eviction reported with hit");

   // an insert never happens when all ENTRIES slots are in use, and only into a free slot
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && decision.insert) |-> (occ_ff < OCC_W'(ENTRIES)) && !valid_ff[slot])
      else $error("insert into occupied slot");

endmodule

`default_nettype wire
